// ===== rtl/core/scn_pkg.sv =====
// ----------------------------------------------------------------------------
// scn_pkg
// Shared widths, register indexes, reset values and controller/datapath
// command and status types for the bouncing scanner.
// ----------------------------------------------------------------------------
package scn_pkg;

  // fixed point format of the head position
  localparam int PosFracBits = 16;
  localparam int PosW        = 26;
  localparam int MaxLeds     = 1024;

  // field widths
  localparam int IdxW      = 10;
  localparam int ElapsedW  = 16;
  localparam int NumLedsW  = 11;
  localparam int CycW      = 16;
  localparam int TailW     = 16;
  localparam int RedW      = 8;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;

  // tail length in position units
  localparam int TailPW    = TailW + PosFracBits - 8;

  // arithmetic widths
  localparam int ProdW     = 32;
  localparam int StepNumW  = PosW + 1;
  localparam int DvdW      = StepNumW + PosFracBits;
  localparam int QuoW      = PosW + 1;
  localparam int RemW      = TailPW;
  localparam int CntW      = $clog2(DvdW + 1);

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgEnable  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNumLeds = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCycle   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgTail    = 2'd3;

  // register reset values
  localparam logic [NumLedsW-1:0] NumLedsRst = NumLedsW'(60);
  localparam logic [CycW-1:0]     CycRst     = CycW'(5000);
  localparam logic [TailW-1:0]    TailRst    = TailW'(3840);

  // item operations
  localparam logic OpAdvance = 1'b0;
  localparam logic OpRender  = 1'b1;

  localparam logic [RedW-1:0] RedFull = 8'd255;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic prep;
    logic div_start;
    logic update;
    logic load_out;
  } scn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } scn_sts_t;

endpackage

// ===== rtl/core/scn_in_if.sv =====
// ----------------------------------------------------------------------------
// scn_in_if
// Item channel into the scanner: operation, elapsed time and pixel index.
// ----------------------------------------------------------------------------
interface scn_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] elapsed_ms;
  logic [9:0]  pixel_index;

  modport source (output valid, output op, output elapsed_ms, output pixel_index,
                  input ready);
  modport sink   (input valid, input op, input elapsed_ms, input pixel_index,
                  output ready);
endinterface

// ===== rtl/core/scn_out_if.sv =====
// ----------------------------------------------------------------------------
// scn_out_if
// Result channel out of the scanner: shade, drawn flag and head state.
// ----------------------------------------------------------------------------
interface scn_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic        drawn;
  logic [25:0] head_position;
  logic        moving_forward;

  modport source (output valid, output red, output drawn, output head_position,
                  output moving_forward, input ready);
  modport sink   (input valid, input red, input drawn, input head_position,
                  input moving_forward, output ready);
endinterface

// ===== rtl/core/scn_cfg_if.sv =====
// ----------------------------------------------------------------------------
// scn_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface scn_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/bouncing_scanner_with_fading_tail.sv =====
// ----------------------------------------------------------------------------
// bouncing_scanner_with_fading_tail
// Bouncing head with a fading red tail, advanced and shaded item by item.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries items: op 0 advances the head by elapsed_ms, op 1 asks for
//   the shade of pixel_index. Every item yields exactly one transfer on out_o
//   with red, drawn, and the head position and direction after the item.
//   cfg_i writes the four registers (enable, num_leds, cycle_time_ms,
//   tail_length_q8) by index; it is always ready and is meant to be used
//   while no item is in flight. Writing enable as 1 parks the head at 0,
//   moving forward.
//   An item that needs no division goes from capture through preparation and
//   the check straight to the result register; a moving advance runs 43 divider
//   steps and a tail pixel 32 divider steps. Items are handled one at a time
//   and the input is ready again in the cycle after the hand-over, so a new
//   item is taken only once the previous one has been handed over.
//   A finished result waits in the output register while a stalled receiver
//   holds off; the next item is still taken and computed, and is handed over
//   once the register is free.
//   Reset clears the registers to their defaults, the head to 0 moving
//   forward, and empties the output register.
// ----------------------------------------------------------------------------
module bouncing_scanner_with_fading_tail import scn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  scn_in_if.sink    in_i,
  scn_out_if.source out_o,
  scn_cfg_if.sink   cfg_i
);

  scn_cmd_t cmd;
  scn_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  assign cfg_i.ready = 1'b1;

  scn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  scn_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .op_i       (in_i.op),
    .elapsed_i  (in_i.elapsed_ms),
    .pixel_i    (in_i.pixel_index),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .red_o      (out_o.red),
    .drawn_o    (out_o.drawn),
    .head_o     (out_o.head_position),
    .fwd_o      (out_o.moving_forward)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  // checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> !in_ready)
    else $error("item taken while the previous one is still in work");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid || out_o.ready))
    else $error("result register overwritten before its transfer");

  a_div_not_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !sts.div_done)
    else $error("divider finished one cycle after start");

  a_dark_when_not_drawn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_o.drawn) |-> (out_o.red == '0))
    else $error("pixel shaded although not drawn");

endmodule

// ===== rtl/core/scn_div.sv =====
// ----------------------------------------------------------------------------
// scn_div
// Restoring bit-serial divider, one quotient bit per cycle. The dividend is
// left aligned and the iteration count sets how many bits are consumed.
// Quotient bits beyond QuoW raise a sticky overflow flag.
// ----------------------------------------------------------------------------
module scn_div import scn_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [RemW-1:0] divisor_i,
  input  logic [CntW-1:0] iters_i,
  output logic            done_o,
  output logic [QuoW-1:0] quo_o,
  output logic            ovf_o
);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DvdW-1:0] dvd_q;
  logic [RemW-1:0] dsr_q, rem_q, rem_d;
  logic [QuoW-1:0] quo_q;
  logic            ovf_q;
  logic [RemW:0]   trial;
  logic            fits;

  // one restoring step
  assign trial = {rem_q, dvd_q[DvdW-1]};
  assign fits  = trial >= {1'b0, dsr_q};
  always_comb begin
    if (fits) begin
      rem_d = RemW'(trial - {1'b0, dsr_q});
    end else begin
      rem_d = trial[RemW-1:0];
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= iters_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[QuoW-2:0], fits};
      ovf_q <= ovf_q | quo_q[QuoW-1];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign ovf_o  = ovf_q;

endmodule

// ===== rtl/core/scn_dp.sv =====
// ----------------------------------------------------------------------------
// scn_dp
// Scanner datapath: registers, head state, step and shade arithmetic,
// shared divider and the result register.
// ----------------------------------------------------------------------------
module scn_dp import scn_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // register writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // item payload
  input  logic                op_i,
  input  logic [ElapsedW-1:0] elapsed_i,
  input  logic [IdxW-1:0]     pixel_i,
  // control
  input  scn_cmd_t            cmd_i,
  output scn_sts_t            sts_o,
  // result payload
  output logic [RedW-1:0]     red_o,
  output logic                drawn_o,
  output logic [PosW-1:0]     head_o,
  output logic                fwd_o
);

  // registers and head state
  logic                en_q;
  logic [NumLedsW-1:0] nleds_q;
  logic [CycW-1:0]     cyc_q;
  logic [TailW-1:0]    tail_q;
  logic [PosW-1:0]     head_q, head_d;
  logic                fwd_q, fwd_d;

  // captured item and working values
  logic                op_q;
  logic [ElapsedW-1:0] elapsed_q;
  logic [IdxW-1:0]     idx_q;
  logic [ProdW-1:0]    prod_q, prod_d;
  logic [RedW-1:0]     red_q, red_d;
  logic                drawn_q, drawn_d;
  logic                need_div_q, need_div_d;

  // result register
  logic [RedW-1:0]     out_red_q;
  logic                out_drawn_q;
  logic [PosW-1:0]     out_head_q;
  logic                out_fwd_q;

  // combinational terms
  logic [NumLedsW-1:0] n_w, nm1_w;
  logic [PosW-1:0]     lim_w;
  logic                adv_active;
  logic [PosW:0]       rnd_w;
  logic [NumLedsW-1:0] hidx_w;
  logic [PosW-1:0]     p_w, d_w;
  logic [TailPW-1:0]   tailp_w, diff_w;
  logic                full_w, dark_w, in_strip;
  logic [DvdW-1:0]     div_dvd;
  logic [RemW-1:0]     div_dsr;
  logic [CntW-1:0]     div_iters;
  logic                div_done;
  logic [QuoW-1:0]     div_quo;
  logic                div_ovf;
  logic [PosW-1:0]     step_w;
  logic [PosW:0]       sum_w, refl_w;

  // strip geometry
  assign n_w        = (nleds_q > NumLedsW'(MaxLeds)) ? NumLedsW'(MaxLeds) : nleds_q;
  assign nm1_w      = n_w - NumLedsW'(1);
  assign lim_w      = PosW'({nm1_w, PosFracBits'(0)});
  assign adv_active = en_q && (n_w >= NumLedsW'(2)) && (cyc_q != '0);

  // shading terms
  assign rnd_w    = {1'b0, head_q} + (PosW+1)'(1 << (PosFracBits - 1));
  assign hidx_w   = NumLedsW'(rnd_w[PosW:PosFracBits]);
  assign p_w      = PosW'({idx_q, PosFracBits'(0)});
  assign d_w      = (p_w >= head_q) ? (p_w - head_q) : (head_q - p_w);
  assign tailp_w  = TailPW'({tail_q, (PosFracBits - 8)'(0)});
  assign diff_w   = tailp_w - TailPW'(d_w);
  assign in_strip = en_q && (NumLedsW'(idx_q) < n_w);
  assign full_w   = NumLedsW'(idx_q) == hidx_w;
  assign dark_w   = (tail_q == '0) || (d_w > PosW'(tailp_w));

  // preparation step
  always_comb begin
    prod_d     = prod_q;
    red_d      = red_q;
    drawn_d    = drawn_q;
    need_div_d = need_div_q;
    if (cmd_i.prep) begin
      red_d   = '0;
      drawn_d = 1'b0;
      if (op_q == OpAdvance) begin
        prod_d     = (ProdW'(nm1_w) * ProdW'(elapsed_q)) << 1;
        need_div_d = adv_active;
      end else begin
        prod_d     = (ProdW'(diff_w) << 8) - ProdW'(diff_w);
        drawn_d    = in_strip;
        need_div_d = in_strip && !full_w && !dark_w;
        if (in_strip && full_w) begin
          red_d = RedFull;
        end
      end
    end else if (cmd_i.update && op_q == OpRender) begin
      red_d = div_quo[RedW-1:0];
    end
  end

  // divider operands
  always_comb begin
    if (op_q == OpAdvance) begin
      div_dvd   = {prod_q[StepNumW-1:0], PosFracBits'(0)};
      div_dsr   = RemW'(cyc_q);
      div_iters = CntW'(DvdW);
    end else begin
      div_dvd   = {prod_q, (DvdW - ProdW)'(0)};
      div_dsr   = RemW'(tailp_w);
      div_iters = CntW'(ProdW);
    end
  end

  scn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .iters_i    (div_iters),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .ovf_o      (div_ovf)
  );

  // head movement: park on enable, clamp on prep, step and reflect on update
  assign step_w = (div_ovf || (div_quo > {1'b0, lim_w})) ? lim_w : div_quo[PosW-1:0];
  assign sum_w  = {1'b0, head_q} + {1'b0, step_w};
  assign refl_w = {lim_w, 1'b0} - sum_w;

  always_comb begin
    head_d = head_q;
    fwd_d  = fwd_q;
    if (cfg_we_i && cfg_idx_i == CfgEnable && cfg_data_i[0]) begin
      head_d = '0;
      fwd_d  = 1'b1;
    end else if (cmd_i.prep && op_q == OpAdvance && adv_active && head_q > lim_w) begin
      head_d = lim_w;
    end else if (cmd_i.update && op_q == OpAdvance) begin
      if (fwd_q) begin
        if (sum_w >= {1'b0, lim_w}) begin
          head_d = refl_w[PosW-1:0];
          fwd_d  = 1'b0;
        end else begin
          head_d = sum_w[PosW-1:0];
        end
      end else if (step_w >= head_q) begin
        head_d = step_w - head_q;
        fwd_d  = 1'b1;
      end else begin
        head_d = head_q - step_w;
      end
    end
  end

  // register file and head state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b0;
      nleds_q <= NumLedsRst;
      cyc_q   <= CycRst;
      tail_q  <= TailRst;
      head_q  <= '0;
      fwd_q   <= 1'b1;
    end else begin
      head_q <= head_d;
      fwd_q  <= fwd_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgEnable:  en_q    <= cfg_data_i[0];
          CfgNumLeds: nleds_q <= cfg_data_i[NumLedsW-1:0];
          CfgCycle:   cyc_q   <= cfg_data_i[CycW-1:0];
          CfgTail:    tail_q  <= cfg_data_i[TailW-1:0];
          default: ;
        endcase
      end
    end
  end

  // item capture and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_i;
      elapsed_q <= elapsed_i;
      idx_q     <= pixel_i;
    end
    prod_q     <= prod_d;
    red_q      <= red_d;
    drawn_q    <= drawn_d;
    need_div_q <= need_div_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_red_q   <= red_q;
      out_drawn_q <= drawn_q;
      out_head_q  <= head_q;
      out_fwd_q   <= fwd_q;
    end
  end

  assign sts_o.need_div = need_div_q;
  assign sts_o.div_done = div_done;

  assign red_o   = out_red_q;
  assign drawn_o = out_drawn_q;
  assign head_o  = out_head_q;
  assign fwd_o   = out_fwd_q;

endmodule

// ===== rtl/core/scn_ctrl.sv =====
// ----------------------------------------------------------------------------
// scn_ctrl
// Scanner controller: sequences capture, preparation, division, update and
// the hand-over to the result register, and owns the channel handshakes.
// ----------------------------------------------------------------------------
module scn_ctrl import scn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  scn_sts_t sts_i,
  output scn_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_CHK;
      end
      S_CHK: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule
